FILE: src/rgcu_pkg.sv
// shared types and constants for the rotator goto command unit
// no dependencies; used by every module under src
`default_nettype none

package rgcu_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam int unsigned AzW    = 9;
  localparam int unsigned ElW    = 8;
  localparam int unsigned HoldW  = 19;
  localparam int unsigned MsW    = 10;
  localparam int unsigned PaddrW = 5;

  // configuration register indexes
  localparam logic [2:0] RegFlip   = 3'd0;
  localparam logic [2:0] RegAzMs   = 3'd1;
  localparam logic [2:0] RegElMs   = 3'd2;
  localparam logic [2:0] RegSpare  = 3'd3;
  localparam logic [2:0] RegSettle = 3'd4;

  localparam logic [MsW-1:0] AzMsReset     = 10'd190;
  localparam logic [MsW-1:0] ElMsReset     = 10'd460;
  localparam logic [MsW-1:0] SpareReset    = 10'd300;
  localparam logic [MsW-1:0] SettleReset   = 10'd100;

  typedef enum logic [1:0] {
    REQ_MOVE   = 2'd0,
    REQ_TICK   = 2'd1,
    REQ_REPORT = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    ST_SENT = 2'd0,
    ST_THERE = 2'd1,
    ST_BUSY = 2'd2
  } move_status_e;

  typedef struct packed {
    logic           flip;
    logic [MsW-1:0] az_ms;
    logic [MsW-1:0] el_ms;
    logic [MsW-1:0] spare;
    logic [MsW-1:0] settle;
  } cfg_t;

  // one answer to a move: status and, when sent, the new position
  typedef struct packed {
    move_status_e   status;
    logic [AzW-1:0] az;
    logic [ElW-1:0] el;
  } job_t;

endpackage

`default_nettype wire

FILE: src/rgcu_queue.sv
// short queue of move answers between the front and the back
// depends on rgcu_pkg
`default_nettype none

module rgcu_queue #(
  parameter int unsigned Depth = rgcu_pkg::QueueDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire rgcu_pkg::job_t push_data_i,
  output      logic          full_o,
  input  wire logic          pop_i,
  output rgcu_pkg::job_t     pop_data_o,
  output      logic          empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  rgcu_pkg::job_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == FullCnt);
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/rgcu_front.sv
// front part: takes requests, keeps position and hold-off timer, queues move answers
// depends on rgcu_pkg
`default_nettype none

module rgcu_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire rgcu_pkg::cfg_t cfg_i,
  input  wire logic          in_valid_i,
  output      logic          in_ready_o,
  input  wire logic [1:0]    req_type_i,
  input  wire logic [10:0]   target_az_i,
  input  wire logic [9:0]    target_el_i,
  output      logic          push_o,
  output rgcu_pkg::job_t     push_data_o,
  input  wire logic          full_i
);

  localparam int unsigned AzW   = rgcu_pkg::AzW;
  localparam int unsigned ElW   = rgcu_pkg::ElW;
  localparam int unsigned HoldW = rgcu_pkg::HoldW;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MUL,
    PH_SUM
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [AzW-1:0]   pos_az_q, pos_az_d;
  logic [ElW-1:0]   pos_el_q, pos_el_d;
  logic [HoldW-1:0] hold_q, hold_d;
  logic [AzW-1:0]   daz_q, daz_d;
  logic [ElW-1:0]   del_q, del_d;
  logic [HoldW-1:0] taz_q, taz_d;
  logic [HoldW-1:0] tel_q, tel_d;

  logic             accept;
  logic signed [11:0] az_raw, el_raw, az_mv, el_mv;
  logic [AzW-1:0]   rep_az, new_az;
  logic [ElW-1:0]   rep_el, new_el;
  logic [HoldW-1:0] t_max;
  logic [HoldW:0]   hold_sum;

  function automatic logic [AzW-1:0] clip_az(input logic signed [11:0] v);
    if (v < 12'sd0) begin
      return '0;
    end else if (v > 12'sd360) begin
      return AzW'(360);
    end
    return v[AzW-1:0];
  endfunction

  function automatic logic [ElW-1:0] clip_el(input logic signed [11:0] v);
    if (v < 12'sd0) begin
      return '0;
    end else if (v > 12'sd180) begin
      return ElW'(180);
    end
    return v[ElW-1:0];
  endfunction

  assign in_ready_o = (phase_q == PH_IDLE) && !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    az_raw = {target_az_i[10], target_az_i};
    el_raw = {{2{target_el_i[9]}}, target_el_i};
    az_mv  = az_raw;
    el_mv  = el_raw;
    if (cfg_i.flip) begin
      el_mv = 12'sd180 - el_raw;
      az_mv = az_raw + 12'sd180;
      if (az_mv > 12'sd360) begin
        az_mv = az_mv - 12'sd360;
      end
    end
    rep_az = clip_az(az_raw);
    rep_el = clip_el(el_raw);
    new_az = clip_az(az_mv);
    new_el = clip_el(el_mv);
  end

  // slower axis time plus margins, wraps at the timer width
  assign t_max    = (taz_q > tel_q) ? taz_q : tel_q;
  assign hold_sum = {1'b0, t_max} + (HoldW + 1)'(cfg_i.spare) + (HoldW + 1)'(cfg_i.settle);

  always_comb begin
    phase_d     = phase_q;
    pos_az_d    = pos_az_q;
    pos_el_d    = pos_el_q;
    hold_d      = hold_q;
    daz_d       = daz_q;
    del_d       = del_q;
    taz_d       = taz_q;
    tel_d       = tel_q;
    push_o      = 1'b0;
    push_data_o.status = rgcu_pkg::ST_SENT;
    push_data_o.az     = new_az;
    push_data_o.el     = new_el;
    case (phase_q)
      PH_IDLE: begin
        if (accept) begin
          case (rgcu_pkg::req_type_e'(req_type_i))
            rgcu_pkg::REQ_TICK: begin
              if (hold_q != '0) begin
                hold_d = hold_q - 1'b1;
              end
            end
            rgcu_pkg::REQ_REPORT: begin
              pos_az_d = rep_az;
              pos_el_d = rep_el;
            end
            rgcu_pkg::REQ_MOVE: begin
              push_o = 1'b1;
              if (hold_q != '0) begin
                push_data_o.status = rgcu_pkg::ST_BUSY;
              end else if (new_az == pos_az_q && new_el == pos_el_q) begin
                push_data_o.status = rgcu_pkg::ST_THERE;
              end else begin
                pos_az_d = new_az;
                pos_el_d = new_el;
                daz_d    = (new_az > pos_az_q) ? new_az - pos_az_q : pos_az_q - new_az;
                del_d    = (new_el > pos_el_q) ? new_el - pos_el_q : pos_el_q - new_el;
                phase_d  = PH_MUL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      PH_MUL: begin
        taz_d   = HoldW'(cfg_i.az_ms) * HoldW'(daz_q);
        tel_d   = HoldW'(cfg_i.el_ms) * HoldW'(del_q);
        phase_d = PH_SUM;
      end
      PH_SUM: begin
        hold_d  = hold_sum[HoldW-1:0];
        phase_d = PH_IDLE;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      pos_az_q <= '0;
      pos_el_q <= '0;
      hold_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      pos_az_q <= pos_az_d;
      pos_el_q <= pos_el_d;
      hold_q   <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    daz_q <= daz_d;
    del_q <= del_d;
    taz_q <= taz_d;
    tel_q <= tel_d;
  end

endmodule

`default_nettype wire

FILE: src/rgcu_back.sv
// back part: turns queued move answers into status results and command bytes
// depends on rgcu_pkg
`default_nettype none

module rgcu_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire rgcu_pkg::job_t job_i,
  input  wire logic          empty_i,
  output      logic          pop_o,
  output      logic          out_valid_o,
  input  wire logic          out_ready_i,
  output      logic [1:0]    move_status_o,
  output      logic [7:0]    cmd_byte_o,
  output      logic          last_of_run_o
);

  localparam logic [7:0] ChW     = 8'h57;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [3:0] LastIdx = 4'd9;

  typedef struct packed {
    logic [3:0] hun;
    logic [3:0] ten;
    logic [3:0] one;
  } digits_t;

  rgcu_pkg::job_t job_q, job_d;
  logic           busy_q, busy_d;
  logic [3:0]     idx_q, idx_d;
  logic           valid_q, valid_d;
  logic [1:0]     status_q, status_d;
  logic [7:0]     byte_q, byte_d;
  logic           last_q, last_d;

  logic           out_free, adv, last_now, load;
  digits_t        az_dig, el_dig;
  logic [7:0]     cur_byte;

  // values stay below 400: hundreds by compare, tens by reciprocal multiply
  function automatic digits_t to_digits(input logic [8:0] v);
    logic [8:0]  rem;
    logic [14:0] scaled;
    digits_t     d;
    if (v >= 9'd300) begin
      d.hun = 4'd3;
      rem   = v - 9'd300;
    end else if (v >= 9'd200) begin
      d.hun = 4'd2;
      rem   = v - 9'd200;
    end else if (v >= 9'd100) begin
      d.hun = 4'd1;
      rem   = v - 9'd100;
    end else begin
      d.hun = 4'd0;
      rem   = v;
    end
    scaled = 15'(rem[6:0]) * 15'd205;
    d.ten  = scaled[14:11];
    d.one  = 4'(rem[6:0] - 7'(d.ten) * 7'd10);
    return d;
  endfunction

  assign az_dig = to_digits(job_q.az);
  assign el_dig = to_digits({1'b0, job_q.el});

  always_comb begin
    case (idx_q)
      4'd0:    cur_byte = ChW;
      4'd1:    cur_byte = ChZero + 8'(az_dig.hun);
      4'd2:    cur_byte = ChZero + 8'(az_dig.ten);
      4'd3:    cur_byte = ChZero + 8'(az_dig.one);
      4'd4:    cur_byte = ChSpace;
      4'd5:    cur_byte = ChZero + 8'(el_dig.hun);
      4'd6:    cur_byte = ChZero + 8'(el_dig.ten);
      4'd7:    cur_byte = ChZero + 8'(el_dig.one);
      4'd8:    cur_byte = ChCr;
      4'd9:    cur_byte = ChLf;
      default: cur_byte = 8'h00;
    endcase
  end

  assign out_free = !valid_q || out_ready_i;
  assign adv      = busy_q && out_free;
  assign last_now = (job_q.status != rgcu_pkg::ST_SENT) || (idx_q == LastIdx);
  assign load     = (!busy_q || (adv && last_now)) && !empty_i;
  assign pop_o    = load;

  always_comb begin
    job_d    = job_q;
    busy_d   = busy_q;
    idx_d    = idx_q;
    valid_d  = valid_q;
    status_d = status_q;
    byte_d   = byte_q;
    last_d   = last_q;
    if (adv) begin
      valid_d  = 1'b1;
      status_d = job_q.status;
      byte_d   = (job_q.status == rgcu_pkg::ST_SENT) ? cur_byte : 8'h00;
      last_d   = last_now;
      idx_d    = idx_q + 1'b1;
      if (last_now) begin
        busy_d = 1'b0;
      end
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (load) begin
      job_d  = job_i;
      busy_d = 1'b1;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    status_q <= status_d;
    byte_q   <= byte_d;
    last_q   <= last_d;
  end

  assign out_valid_o   = valid_q;
  assign move_status_o = status_q;
  assign cmd_byte_o    = byte_q;
  assign last_of_run_o = last_q;

endmodule

`default_nettype wire

FILE: src/rotator_goto_command_unit.sv
// top level of the rotator goto command unit: register file, front, queue, back
// depends on rgcu_pkg, rgcu_front, rgcu_queue and rgcu_back
`default_nettype none

// Takes move requests, millisecond ticks and position reports on the slave stream and
// answers each move on the master stream: either one status result (refused while the
// hold-off timer runs, or already at target) or the ten command bytes W aaa space eee CR LF.
// Ticks and position reports give no result. A move that is sent keeps the input stalled
// through the multiply and sum phases while the multiplier and adder load the hold-off
// timer. The back end gives one result per cycle while the master stream is ready, so a
// sent move occupies the output for ten command bytes; the queue of move answers between
// the two sides lets ticks and reports flow on while bytes drain, as long as it is not full.
module rotator_goto_command_unit #(
  parameter int unsigned QueueDepth = rgcu_pkg::QueueDepth  // 2 or more
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // target_az [10:0], target_el [20:11], zero pad
  input  wire logic [1:0]  s_axis_tuser,   // req_type [1:0]
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [7:0]  m_axis_tdata,   // cmd_byte [7:0]
  output      logic [1:0]  m_axis_tuser,   // move_status [1:0]
  output      logic        m_axis_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [rgcu_pkg::PaddrW-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  localparam int unsigned MsW = rgcu_pkg::MsW;

  rgcu_pkg::cfg_t cfg_q, cfg_d;
  rgcu_pkg::job_t push_data, pop_data;
  logic           push, pop, full, empty, cfg_wr;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_idx)
        rgcu_pkg::RegFlip:   cfg_d.flip   = pwdata[0];
        rgcu_pkg::RegAzMs:   cfg_d.az_ms  = pwdata[MsW-1:0];
        rgcu_pkg::RegElMs:   cfg_d.el_ms  = pwdata[MsW-1:0];
        rgcu_pkg::RegSpare:  cfg_d.spare  = pwdata[MsW-1:0];
        rgcu_pkg::RegSettle: cfg_d.settle = pwdata[MsW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rgcu_pkg::RegFlip:   prdata = 32'(cfg_q.flip);
      rgcu_pkg::RegAzMs:   prdata = 32'(cfg_q.az_ms);
      rgcu_pkg::RegElMs:   prdata = 32'(cfg_q.el_ms);
      rgcu_pkg::RegSpare:  prdata = 32'(cfg_q.spare);
      rgcu_pkg::RegSettle: prdata = 32'(cfg_q.settle);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flip   <= 1'b0;
      cfg_q.az_ms  <= rgcu_pkg::AzMsReset;
      cfg_q.el_ms  <= rgcu_pkg::ElMsReset;
      cfg_q.spare  <= rgcu_pkg::SpareReset;
      cfg_q.settle <= rgcu_pkg::SettleReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rgcu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .req_type_i  (s_axis_tuser),
    .target_az_i (s_axis_tdata[10:0]),
    .target_el_i (s_axis_tdata[20:11]),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  rgcu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  rgcu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (pop_data),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .move_status_o (m_axis_tuser),
    .cmd_byte_o    (m_axis_tdata),
    .last_of_run_o (m_axis_tlast)
  );

endmodule

`default_nettype wire
